[hw/rtl/grid_astar_path_search_assert.svh]
// Assertion macros for the grid A* search block.
// Used by the port-level checker; needs a clock named i_clk and reset i_rst_n.
`ifndef GRID_ASTAR_PATH_SEARCH_ASSERT_SVH
`define GRID_ASTAR_PATH_SEARCH_ASSERT_SVH

// same-cycle implication
`define GAPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gaps: check failed");

// next-cycle implication
`define GAPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gaps: check failed");

`endif

[hw/rtl/gaps_pkg.sv]
// Package for the grid A* search block: item/result types, cell entry,
// controller states, mode codes and the octile distance function. No dependencies.
`default_nettype none

package gaps_pkg;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam int COST_W   = 16;
    localparam int PARENT_W = 16;
    localparam logic [11:0] STEP_STRAIGHT = 12'd10;
    localparam logic [11:0] STEP_DIAG     = 12'd14;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic       walkable;
        logic [4:0] start_x;
        logic [4:0] start_y;
        logic [4:0] finish_x;
        logic [4:0] finish_y;
    } t_item;

    typedef struct packed {
        logic        found;
        logic        on_path;
        logic [15:0] cell_cost;
    } t_res;

    typedef struct packed {
        logic                passable;
        logic                is_open;
        logic                is_closed;
        logic                on_path;
        logic [COST_W-1:0]   g;
        logic [COST_W-1:0]   f;
        logic [PARENT_W-1:0] parent;
    } t_cell;

    typedef enum logic [4:0] {
        S_IDLE, S_NULL, S_CLR, S_ST_RD, S_ST_WB, S_SCAN, S_CUR_RD, S_CUR_WB,
        S_NB, S_NA, S_NBB, S_NC, S_PATH, S_PW, S_W_RD, S_W_WB, S_Q_RD, S_Q_OUT
    } t_state;

    function automatic logic [11:0] octile(input logic [7:0] ax, input logic [7:0] ay,
                                           input logic [7:0] bx, input logic [7:0] by);
        logic [7:0] dx;
        logic [7:0] dy;
        logic [7:0] mn;
        logic [7:0] mx;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        mn = (dx > dy) ? dy : dx;
        mx = (dx > dy) ? dx : dy;
        return 12'(12'(mn) * STEP_DIAG + 12'(mx - mn) * STEP_STRAIGHT);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/grid_astar_path_search.sv]
// Grid A* search block: controller sequencing reads and writes of the cell memory.
// Depends on gaps_pkg and gaps_cell_ram.
//
// An item is taken when start is high and busy is low; its result appears on o_result
// with o_strobe for one cycle and cannot be held off. After reset the block sweeps the
// cell memory with busy high. A cell write reads the cell and writes it back; a query
// reads the cell and returns its cost and path mark. A search clears the marks, then
// each expansion scans all cells through the single read port, closes the chosen cell
// and checks each neighbour in turn, reading its two side cells and then the cell
// itself; marking the path reads and rewrites each path cell. All timing is set by
// the one-read, one-write cell memory.
`default_nettype none

module grid_astar_path_search #(
    parameter int GRID_W = 32,
    parameter int GRID_H = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire gaps_pkg::t_item i_item,
    output logic                 busy,
    output logic                 o_strobe,
    output gaps_pkg::t_res       o_result
);
    import gaps_pkg::*;

    localparam int NC = GRID_W * GRID_H;
    localparam int IW = $clog2(NC);
    localparam int CW = IW + 1;
    localparam int XW = $clog2(GRID_W);
    localparam int YW = $clog2(GRID_H);

    function automatic logic [IW-1:0] idx(input logic [XW-1:0] x, input logic [YW-1:0] y);
        return IW'(32'(y) * GRID_W + 32'(x));
    endfunction

    t_state r_state, n_state;
    t_item  r_item, n_item;
    logic   r_init, n_init;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [XW-1:0] r_x, n_x, r_px, n_px, r_bx, n_bx, r_cx, n_cx, r_nx, n_nx;
    logic [YW-1:0] r_y, n_y, r_py, n_py, r_by, n_by, r_cy, n_cy, r_ny, n_ny;
    logic   r_pv, n_pv, r_have, n_have, r_pa, n_pa;
    logic [IW-1:0] r_pidx, n_pidx, r_best, n_best, r_cur, n_cur, r_node, n_node;
    logic [COST_W-1:0] r_bf, n_bf, r_cg, n_cg;
    logic [3:0] r_k, n_k;
    logic [CW-1:0] r_guard, n_guard;
    logic   r_valid, n_valid;
    t_res   r_res, n_res;

    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    t_cell         ram_wdata, rd;

    logic [XW-1:0] sx, fx, qx;
    logic [YW-1:0] sy, fy, qy;
    logic [IW-1:0] sidx, fidx;
    logic [1:0]    kdx, kdy;
    logic          nb_ok;
    logic [XW-1:0] tnx;
    logic [YW-1:0] tny;
    logic [16:0]   t_sum, f_sum;
    logic [COST_W-1:0] g_sat;
    logic [11:0]   hdist;

    gaps_cell_ram #(.DEPTH(NC), .AW(IW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_init  <= 1'b1;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_cnt   <= n_cnt;
            r_pv    <= n_pv;
            r_valid <= n_valid;
        end
        r_item  <= n_item;
        r_x     <= n_x;
        r_y     <= n_y;
        r_px    <= n_px;
        r_py    <= n_py;
        r_pidx  <= n_pidx;
        r_have  <= n_have;
        r_best  <= n_best;
        r_bx    <= n_bx;
        r_by    <= n_by;
        r_bf    <= n_bf;
        r_cur   <= n_cur;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_cg    <= n_cg;
        r_k     <= n_k;
        r_nx    <= n_nx;
        r_ny    <= n_ny;
        r_pa    <= n_pa;
        r_node  <= n_node;
        r_guard <= n_guard;
        r_res   <= n_res;
    end

    assign sx   = XW'(r_item.start_x);
    assign sy   = YW'(r_item.start_y);
    assign fx   = XW'(r_item.finish_x);
    assign fy   = YW'(r_item.finish_y);
    assign qx   = XW'(r_item.cell_x);
    assign qy   = YW'(r_item.cell_y);
    assign sidx = idx(sx, sy);
    assign fidx = idx(fx, fy);

    always_comb begin
        case (r_k)
            4'd0, 4'd1, 4'd2: kdy = 2'd0;
            4'd3, 4'd4, 4'd5: kdy = 2'd1;
            default:          kdy = 2'd2;
        endcase
        kdx   = 2'(r_k - 4'(3 * kdy));
        nb_ok = (r_k != 4'd4) && (r_k < 4'd9);
        tnx   = r_cx;
        tny   = r_cy;
        if (kdx == 2'd0) begin
            nb_ok = nb_ok && (r_cx != '0);
            tnx   = r_cx - 1'b1;
        end else if (kdx == 2'd2) begin
            nb_ok = nb_ok && (r_cx != XW'(GRID_W - 1));
            tnx   = r_cx + 1'b1;
        end
        if (kdy == 2'd0) begin
            nb_ok = nb_ok && (r_cy != '0);
            tny   = r_cy - 1'b1;
        end else if (kdy == 2'd2) begin
            nb_ok = nb_ok && (r_cy != YW'(GRID_H - 1));
            tny   = r_cy + 1'b1;
        end
    end

    always_comb begin
        t_sum = {1'b0, r_cg} +
                17'(((r_nx != r_cx) && (r_ny != r_cy)) ? STEP_DIAG : STEP_STRAIGHT);
        g_sat = t_sum[16] ? {COST_W{1'b1}} : t_sum[15:0];
        hdist = octile(8'(r_nx), 8'(r_ny), 8'(fx), 8'(fy));
        f_sum = {1'b0, g_sat} + 17'(hdist);
    end

    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        n_init  = r_init;
        n_cnt   = r_cnt;
        n_x     = r_x;
        n_y     = r_y;
        n_px    = r_px;
        n_py    = r_py;
        n_pv    = r_pv;
        n_pidx  = r_pidx;
        n_have  = r_have;
        n_best  = r_best;
        n_bx    = r_bx;
        n_by    = r_by;
        n_bf    = r_bf;
        n_cur   = r_cur;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_cg    = r_cg;
        n_k     = r_k;
        n_nx    = r_nx;
        n_ny    = r_ny;
        n_pa    = r_pa;
        n_node  = r_node;
        n_guard = r_guard;
        n_valid = 1'b0;
        n_res   = '0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = rd;
        ram_re    = 1'b0;
        ram_raddr = '0;
        busy      = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_state = S_NULL;
                    case (i_item.mode)
                        MODE_WRITE: begin
                            if (32'(i_item.cell_x) < GRID_W && 32'(i_item.cell_y) < GRID_H) begin
                                n_state = S_W_RD;
                            end
                        end
                        MODE_SEARCH: begin
                            if (32'(i_item.start_x) < GRID_W && 32'(i_item.start_y) < GRID_H &&
                                32'(i_item.finish_x) < GRID_W &&
                                32'(i_item.finish_y) < GRID_H) begin
                                n_state = S_CLR;
                                n_init  = 1'b0;
                                n_cnt   = '0;
                                n_pv    = 1'b0;
                            end
                        end
                        MODE_QUERY: begin
                            if (32'(i_item.cell_x) < GRID_W && 32'(i_item.cell_y) < GRID_H) begin
                                n_state = S_Q_RD;
                            end
                        end
                        default: n_state = S_NULL;
                    endcase
                end
            end
            S_NULL: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_CLR: begin
                if (r_cnt < CW'(NC)) begin
                    ram_re    = ~r_init;
                    ram_raddr = r_cnt[IW-1:0];
                    n_cnt     = r_cnt + 1'b1;
                end
                n_pv   = (r_cnt < CW'(NC));
                n_pidx = r_cnt[IW-1:0];
                if (r_pv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pidx;
                    if (r_init) begin
                        ram_wdata          = '0;
                        ram_wdata.passable = 1'b1;
                    end else begin
                        ram_wdata.is_open   = 1'b0;
                        ram_wdata.is_closed = 1'b0;
                        ram_wdata.on_path   = 1'b0;
                    end
                end
                if (r_cnt == CW'(NC) && !r_pv) begin
                    n_state = r_init ? S_IDLE : S_ST_RD;
                    n_init  = 1'b0;
                end
            end
            S_ST_RD: begin
                ram_re    = 1'b1;
                ram_raddr = sidx;
                n_state   = S_ST_WB;
            end
            S_ST_WB: begin
                ram_we            = 1'b1;
                ram_waddr         = sidx;
                ram_wdata.g       = '0;
                ram_wdata.is_open = 1'b1;
                n_state = S_SCAN;
                n_cnt   = '0;
                n_x     = '0;
                n_y     = '0;
                n_pv    = 1'b0;
                n_have  = 1'b0;
            end
            S_SCAN: begin
                if (r_cnt < CW'(NC)) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_cnt[IW-1:0];
                    n_cnt     = r_cnt + 1'b1;
                    if (r_x == XW'(GRID_W - 1)) begin
                        n_x = '0;
                        n_y = r_y + 1'b1;
                    end else begin
                        n_x = r_x + 1'b1;
                    end
                end
                n_pv   = (r_cnt < CW'(NC));
                n_pidx = r_cnt[IW-1:0];
                n_px   = r_x;
                n_py   = r_y;
                if (r_pv && rd.is_open && (!r_have || rd.f < r_bf)) begin
                    n_have = 1'b1;
                    n_best = r_pidx;
                    n_bx   = r_px;
                    n_by   = r_py;
                    n_bf   = rd.f;
                end
                if (r_cnt == CW'(NC) && !r_pv) begin
                    if (r_have) begin
                        n_cur   = r_best;
                        n_cx    = r_bx;
                        n_cy    = r_by;
                        n_state = S_CUR_RD;
                    end else begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_CUR_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_cur;
                n_state   = S_CUR_WB;
            end
            S_CUR_WB: begin
                ram_we              = 1'b1;
                ram_waddr           = r_cur;
                ram_wdata.is_open   = 1'b0;
                ram_wdata.is_closed = 1'b1;
                n_cg    = rd.g;
                n_k     = '0;
                n_state = S_NB;
            end
            S_NB: begin
                if (r_k >= 4'd9) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                    n_x     = '0;
                    n_y     = '0;
                    n_pv    = 1'b0;
                    n_have  = 1'b0;
                end else if (!nb_ok) begin
                    n_k = r_k + 1'b1;
                end else begin
                    n_nx      = tnx;
                    n_ny      = tny;
                    ram_re    = 1'b1;
                    ram_raddr = idx(tnx, r_cy);
                    n_state   = S_NA;
                end
            end
            S_NA: begin
                n_pa      = rd.passable;
                ram_re    = 1'b1;
                ram_raddr = idx(r_cx, r_ny);
                n_state   = S_NBB;
            end
            S_NBB: begin
                if (!r_pa && !rd.passable) begin
                    n_k     = r_k + 1'b1;
                    n_state = S_NB;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = idx(r_nx, r_ny);
                    n_state   = S_NC;
                end
            end
            S_NC: begin
                n_k     = r_k + 1'b1;
                n_state = S_NB;
                if (!rd.is_closed && (!rd.is_open || t_sum < {1'b0, rd.g})) begin
                    if (idx(r_nx, r_ny) == fidx) begin
                        n_node  = r_cur;
                        n_guard = '0;
                        n_state = S_PATH;
                    end else if (rd.passable) begin
                        ram_we            = 1'b1;
                        ram_waddr         = idx(r_nx, r_ny);
                        ram_wdata.g       = g_sat;
                        ram_wdata.f       = f_sum[16] ? {COST_W{1'b1}} : f_sum[15:0];
                        ram_wdata.parent  = PARENT_W'(r_cur);
                        ram_wdata.is_open = 1'b1;
                    end
                end
            end
            S_PATH: begin
                if (r_node != sidx && r_guard < CW'(NC)) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_node;
                    n_state   = S_PW;
                end else begin
                    n_valid     = 1'b1;
                    n_res.found = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_PW: begin
                ram_we            = 1'b1;
                ram_waddr         = r_node;
                ram_wdata.on_path = 1'b1;
                n_node  = rd.parent[IW-1:0];
                n_guard = r_guard + 1'b1;
                n_state = S_PATH;
            end
            S_W_RD: begin
                ram_re    = 1'b1;
                ram_raddr = idx(qx, qy);
                n_state   = S_W_WB;
            end
            S_W_WB: begin
                ram_we             = 1'b1;
                ram_waddr          = idx(qx, qy);
                ram_wdata.passable = r_item.walkable;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_Q_RD: begin
                ram_re    = 1'b1;
                ram_raddr = idx(qx, qy);
                n_state   = S_Q_OUT;
            end
            S_Q_OUT: begin
                n_valid         = 1'b1;
                n_res.on_path   = rd.on_path;
                n_res.cell_cost = rd.g;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_strobe = r_valid;
    assign o_result = r_res;

endmodule

`default_nettype wire

[hw/rtl/gaps_cell_ram.sv]
// Cell state memory: one write port, one read port, registered read data.
// Depends on gaps_pkg for the cell entry type.
`default_nettype none

module gaps_cell_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire gaps_pkg::t_cell i_wdata,
    input  wire logic            i_re,
    input  wire logic [AW-1:0]   i_raddr,
    output gaps_pkg::t_cell      o_rdata
);
    import gaps_pkg::*;

    t_cell mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/gaps_check.sv]
// Port-level checker for the grid A* search block, bound to the top level.
// Depends on gaps_pkg and grid_astar_path_search_assert.svh.
`default_nettype none

`include "grid_astar_path_search_assert.svh"

module gaps_check (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           o_strobe,
    input wire gaps_pkg::t_res o_result
);
    import gaps_pkg::*;

    `GAPS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `GAPS_ASSERT_NOW(a_strobe_idle, o_strobe, !busy)
    `GAPS_ASSERT_NEXT(a_strobe_single, o_strobe, !o_strobe)
    `GAPS_ASSERT_NOW(a_found_clean, o_strobe && o_result.found, !o_result.on_path && o_result.cell_cost == 16'd0)

endmodule

bind grid_astar_path_search gaps_check u_gaps_check (.*);

`default_nettype wire

[tb/sv/testbench.sv]
// Testbench for grid_astar_path_search: directed table then random writes/searches/queries/nulls.
// Depends on gaps_pkg and the block's RTL; a local A* predictor supplies expected results.
`timescale 1ns / 100ps

module testbench;
    import gaps_pkg::*;

    localparam int W = 32;
    localparam int H = 32;
    localparam int NC = W * H;
    localparam int EXP_CAP = 12;
    localparam int N_RAND = 1030;
    localparam logic [1:0] MODE_NONE = 2'd3;

    typedef struct {
        t_item it;
        bit    typed;
        t_res  res;
    } t_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    t_item i_item;
    logic  busy;
    logic  o_strobe;
    t_res  o_result;

    bit          pass_m [NC];
    logic [15:0] g_m [NC];
    logic [15:0] f_m [NC];
    int          par_m [NC];
    bit          open_m [NC];
    bit          clos_m [NC];
    bit          path_m [NC];
    bit          g_known [NC];

    bit          pass_s [NC];
    logic [15:0] g_s [NC];
    logic [15:0] f_s [NC];
    int          par_s [NC];
    bit          open_s [NC];
    bit          clos_s [NC];
    bit          path_s [NC];
    bit          known_s [NC];

    t_res results_due[$];
    t_row table_rows[$];
    int   known_cells[$];
    int   errors;

    grid_astar_path_search uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .i_item(i_item),
        .busy(busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int octile_dist(int ax, int ay, int bx, int by);
        int dx;
        int dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        if (dx > dy) return 14 * dy + 10 * (dx - dy);
        return 14 * dx + 10 * (dy - dx);
    endfunction

    function automatic logic [15:0] sat_cost(int v);
        return (v > 65535) ? 16'hffff : v[15:0];
    endfunction

    function automatic void note_g(int c);
        if (!g_known[c]) begin
            g_known[c] = 1'b1;
            known_cells.push_back(c);
        end
    endfunction

    // returns 1 found, 0 not found, -1 when expansions exceed cap
    function automatic int astar(int sx, int sy, int fx, int fy, int cap);
        int st;
        int fin;
        int cur;
        int nexp;
        int cx;
        int cy;
        int nx;
        int ny;
        int n;
        int t;
        int node;
        int guard;
        st = sy * W + sx;
        fin = fy * W + fx;
        nexp = 0;
        for (int i = 0; i < NC; i++) begin
            path_m[i] = 1'b0;
            open_m[i] = 1'b0;
            clos_m[i] = 1'b0;
        end
        g_m[st] = 16'd0;
        note_g(st);
        open_m[st] = 1'b1;
        forever begin
            cur = NC;
            for (int i = 0; i < NC; i++)
                if (open_m[i] && (cur == NC || f_m[i] < f_m[cur])) cur = i;
            if (cur == NC) return 0;
            nexp++;
            if (nexp > cap) return -1;
            open_m[cur] = 1'b0;
            clos_m[cur] = 1'b1;
            cx = cur % W;
            cy = cur / W;
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                    nx = cx + dx;
                    ny = cy + dy;
                    if (dx == 0 && dy == 0) continue;
                    if (nx < 0 || ny < 0 || nx >= W || ny >= H) continue;
                    n = ny * W + nx;
                    if (!pass_m[cy * W + nx] && !pass_m[ny * W + cx]) continue;
                    if (clos_m[n]) continue;
                    t = int'(g_m[cur]) + octile_dist(cx, cy, nx, ny);
                    if (t < int'(g_m[n]) || !open_m[n]) begin
                        if (n == fin) begin
                            par_m[n] = cur;
                            node = cur;
                            guard = 0;
                            while (node != st && guard < NC) begin
                                path_m[node] = 1'b1;
                                node = par_m[node] % NC;
                                guard++;
                            end
                            return 1;
                        end
                        if (!pass_m[n]) continue;
                        g_m[n] = sat_cost(t);
                        note_g(n);
                        f_m[n] = sat_cost(int'(g_m[n]) + octile_dist(nx, ny, fx, fy));
                        par_m[n] = cur;
                        open_m[n] = 1'b1;
                    end
                end
            end
        end
    endfunction

    // advances the model; returns 0 if a search was too long (state left unchanged)
    function automatic bit predict_item(input t_item it, output t_res r);
        int c;
        int rc;
        int nk;
        r = '0;
        c = int'(it.cell_y) * W + int'(it.cell_x);
        case (it.mode)
            MODE_WRITE: pass_m[c] = it.walkable;
            MODE_QUERY: begin
                r.on_path = path_m[c];
                r.cell_cost = g_m[c];
            end
            MODE_SEARCH: begin
                pass_s = pass_m; g_s = g_m; f_s = f_m; par_s = par_m;
                open_s = open_m; clos_s = clos_m; path_s = path_m; known_s = g_known;
                nk = known_cells.size();
                rc = astar(it.start_x, it.start_y, it.finish_x, it.finish_y, EXP_CAP);
                if (rc < 0) begin
                    pass_m = pass_s; g_m = g_s; f_m = f_s; par_m = par_s;
                    open_m = open_s; clos_m = clos_s; path_m = path_s; g_known = known_s;
                    while (known_cells.size() > nk) void'(known_cells.pop_back());
                    return 1'b0;
                end
                r.found = rc[0];
            end
            default: ;
        endcase
        return 1'b1;
    endfunction

    task automatic send_item(input t_item it, input int gap);
        for (int k = 0; k < gap; k++) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    function automatic t_item make_item(logic [1:0] m, int x, int y, bit wk,
                                        int sx, int sy, int fx, int fy);
        t_item it;
        it.mode = m;
        it.cell_x = x[4:0];
        it.cell_y = y[4:0];
        it.walkable = wk;
        it.start_x = sx[4:0];
        it.start_y = sy[4:0];
        it.finish_x = fx[4:0];
        it.finish_y = fy[4:0];
        return it;
    endfunction

    function automatic void add_row(t_item it, bit typed);
        t_row rw;
        rw.it = it;
        rw.typed = typed;
        rw.res = '0;
        table_rows.push_back(rw);
    endfunction

    function automatic int clip(int v, int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_strobe) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_result);
                errors++;
            end else begin
                want = results_due.pop_front();
                if (o_result.found !== want.found) begin
                    $display("%0t: found exp %0d act %0d", $time, want.found, o_result.found);
                    errors++;
                end
                if (o_result.on_path !== want.on_path) begin
                    $display("%0t: on_path exp %0d act %0d", $time, want.on_path,
                             o_result.on_path);
                    errors++;
                end
                if (o_result.cell_cost !== want.cell_cost) begin
                    $display("%0t: cell_cost exp %0d act %0d", $time, want.cell_cost,
                             o_result.cell_cost);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_item it;
        t_res  r;
        int    sel;
        int    gap;
        int    burst;
        int    sx;
        int    sy;
        errors = 0;
        start = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        for (int i = 0; i < NC; i++) begin
            pass_m[i] = 1'b1;
            g_m[i] = '0;
            f_m[i] = '0;
            par_m[i] = 0;
            open_m[i] = 1'b0;
            clos_m[i] = 1'b0;
            path_m[i] = 1'b0;
            g_known[i] = 1'b0;
        end

        add_row(make_item(MODE_WRITE, 31, 31, 0, 31, 31, 31, 31), 1);
        add_row(make_item(MODE_WRITE, 31, 31, 1, 0, 0, 0, 0), 1);
        add_row(make_item(MODE_NONE, 31, 31, 1, 31, 31, 31, 31), 1);
        add_row(make_item(MODE_WRITE, 1, 0, 0, 0, 0, 0, 0), 1);
        add_row(make_item(MODE_WRITE, 0, 1, 0, 0, 0, 0, 0), 1);
        add_row(make_item(MODE_WRITE, 1, 1, 0, 0, 0, 0, 0), 1);
        // walled-in corner: start equals finish, and an unreachable finish
        add_row(make_item(MODE_SEARCH, 0, 0, 0, 0, 0, 0, 0), 1);
        add_row(make_item(MODE_SEARCH, 0, 0, 0, 0, 0, 31, 31), 1);
        add_row(make_item(MODE_QUERY, 0, 0, 0, 0, 0, 0, 0), 1);
        // blocked start
        add_row(make_item(MODE_WRITE, 0, 0, 0, 0, 0, 0, 0), 1);
        add_row(make_item(MODE_WRITE, 1, 0, 1, 0, 0, 0, 0), 1);
        add_row(make_item(MODE_SEARCH, 0, 0, 0, 0, 0, 3, 0), 0);
        add_row(make_item(MODE_QUERY, 2, 0, 0, 0, 0, 0, 0), 0);
        // blocked finish
        add_row(make_item(MODE_WRITE, 5, 5, 0, 0, 0, 0, 0), 1);
        add_row(make_item(MODE_SEARCH, 0, 0, 0, 3, 5, 5, 5), 0);
        add_row(make_item(MODE_QUERY, 4, 5, 0, 0, 0, 0, 0), 0);
        // far corner, diagonal moves
        add_row(make_item(MODE_SEARCH, 0, 0, 0, 28, 28, 31, 31), 0);
        add_row(make_item(MODE_QUERY, 30, 30, 0, 0, 0, 0, 0), 0);
        // corner cutting blocked when both side cells are walls
        add_row(make_item(MODE_WRITE, 11, 10, 0, 0, 0, 0, 0), 1);
        add_row(make_item(MODE_WRITE, 10, 11, 0, 0, 0, 0, 0), 1);
        add_row(make_item(MODE_SEARCH, 0, 0, 0, 10, 10, 11, 11), 0);
        add_row(make_item(MODE_QUERY, 10, 10, 0, 0, 0, 0, 0), 0);
        add_row(make_item(MODE_QUERY, 29, 29, 1, 31, 31, 31, 31), 0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (table_rows[k]) begin
            it = table_rows[k].it;
            if (!predict_item(it, r)) $display("%0t: directed search over budget", $time);
            if (table_rows[k].typed) r = table_rows[k].res;
            results_due.push_back(r);
            send_item(it, $urandom_range(0, 7));
        end

        burst = 0;
        for (int n = 0; n < N_RAND; n++) begin
            it = t_item'({$urandom, $urandom});
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                sx = $urandom_range(0, W - 1);
                sy = $urandom_range(0, H - 1);
                it.mode = MODE_SEARCH;
                it.start_x = sx[4:0];
                it.start_y = sy[4:0];
                it.finish_x = 5'(clip(sx + $urandom_range(0, 6) - 3, W - 1));
                it.finish_y = 5'(clip(sy + $urandom_range(0, 6) - 3, H - 1));
            end else if (sel < 55) begin
                it.mode = MODE_WRITE;
                it.walkable = ($urandom_range(0, 3) != 0);
            end else if (sel < 96 && known_cells.size() > 0) begin
                sx = known_cells[$urandom_range(0, known_cells.size() - 1)];
                it.mode = MODE_QUERY;
                it.cell_x = 5'(sx % W);
                it.cell_y = 5'(sx / W);
            end else if (sel < 96) begin
                it.mode = MODE_WRITE;
            end else begin
                it.mode = MODE_NONE;
            end
            if (!predict_item(it, r)) begin
                it.mode = MODE_WRITE;
                it.walkable = 1'b1;
                void'(predict_item(it, r));
            end
            if (n == 500) begin
                while (results_due.size() != 0) @(negedge i_clk);
            end
            results_due.push_back(r);
            if (burst > 0) begin
                burst--;
                gap = 0;
            end else begin
                gap = $urandom_range(0, 7);
                if ($urandom_range(0, 15) == 0) burst = $urandom_range(5, 20);
            end
            send_item(it, gap);
        end

        while (results_due.size() != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
